@@ hdl/sle_pkg.sv @@
`default_nettype none

package sle_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed widths of the transaction fields on the ports.
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int FIELD_W  = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT       = 2'd0,
        ACT_REMOVE_FIRST = 2'd1,
        ACT_REMOVE_LAST  = 2'd2,
        ACT_REMOVE_VALUE = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;     // open a slot at the first entry not below the key
        logic pull_all;   // every cell takes its right neighbor
        logic pull_ge;    // cells at or past the key take their right neighbor
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/sorted_list_engine_core.sv @@
`default_nettype none

// Latency: the result strobe done is high in the cycle after start is taken.
// Throughput: one transaction per cycle; busy is never raised, because every
// cell of the chain compares and shifts its entry in the same cycle.
// Reset: rst_n clears the entry count, so the list comes up empty; entry
// cells hold no reset. The receiver cannot stall, and each result shows once.
module sorted_list_engine_core #(
    parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire        [sle_pkg::ACTION_W-1:0]  action,
    input  wire signed [sle_pkg::FIELD_W-1:0]   operand_value,
    output logic                                done,
    output logic       [sle_pkg::STATUS_W-1:0]  status,
    output logic       [sle_pkg::COUNT_W-1:0]   entry_count,
    output logic signed [sle_pkg::FIELD_W-1:0]  smallest,
    output logic signed [sle_pkg::FIELD_W-1:0]  largest
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [VALUE_BITS-1:0] key;
    logic signed [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic        [VALUE_BITS-1:0] cell_tail  [CAPACITY];
    logic        [CAPACITY-1:0]   cell_ge;
    logic        [CAPACITY-1:0]   cell_hit;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 done_reg;
    sle_pkg::status_t     status_reg;
    sle_pkg::status_t     status_next;
    sle_pkg::cell_ctrl_t  ctrl;

    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    logic                 found;
    logic [VALUE_BITS-1:0] head_value;
    logic [VALUE_BITS-1:0] tail_value;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = count_reg == CNT_W'(CAPACITY);
    assign is_empty = count_reg == '0;
    assign found    = |cell_hit;

    generate
        if (VALUE_BITS <= sle_pkg::FIELD_W)
        begin : g_key_narrow
            assign key = operand_value[VALUE_BITS-1:0];
        end
        else
        begin : g_key_wide
            assign key = {{(VALUE_BITS - sle_pkg::FIELD_W){operand_value[sle_pkg::FIELD_W-1]}},
                          operand_value};
        end
    endgenerate

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [VALUE_BITS-1:0] left_v;
            logic signed [VALUE_BITS-1:0] right_v;
            logic                         left_g;

            if (i == 0)
            begin : g_first
                assign left_v = key;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid_left
                assign left_v = cell_value[i-1];
                assign left_g = cell_ge[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_v = cell_value[i];
            end
            else
            begin : g_mid_right
                assign right_v = cell_value[i+1];
            end

            sle_cell #(
                .VALUE_BITS (VALUE_BITS),
                .CNT_W      (CNT_W),
                .IDX        (i)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .key         (key),
                .count       (count_reg),
                .left_value  (left_v),
                .left_ge     (left_g),
                .right_value (right_v),
                .value       (cell_value[i]),
                .ge          (cell_ge[i]),
                .hit         (cell_hit[i]),
                .tail_value  (cell_tail[i])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        status_next = sle_pkg::ST_OK;
        unique case (sle_pkg::action_t'(action))
            sle_pkg::ACT_INSERT:
            begin
                if (is_full)
                begin
                    status_next = sle_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.insert = accept;
                    count_next  = count_reg + 1'b1;
                end
            end
            sle_pkg::ACT_REMOVE_FIRST:
            begin
                if (is_empty)
                begin
                    status_next = sle_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.pull_all = accept;
                    count_next    = count_reg - 1'b1;
                end
            end
            sle_pkg::ACT_REMOVE_LAST:
            begin
                if (is_empty)
                begin
                    status_next = sle_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            sle_pkg::ACT_REMOVE_VALUE:
            begin
                if (is_empty)
                begin
                    status_next = sle_pkg::ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = sle_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    ctrl.pull_ge = accept;
                    count_next   = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = sle_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= sle_pkg::ST_OK;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg  <= count_next;
                status_reg <= status_next;
            end
        end
    end

    // The tail cell is the only one that drives a nonzero tail value.
    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_value = tail_value | cell_tail[i];
        end
    end

    assign head_value = is_empty ? '0 : cell_value[0];

    assign done   = done_reg;
    assign status = status_reg;

    generate
        if (CNT_W >= sle_pkg::COUNT_W)
        begin : g_cnt_trunc
            assign entry_count = count_reg[sle_pkg::COUNT_W-1:0];
        end
        else
        begin : g_cnt_ext
            assign entry_count = {{(sle_pkg::COUNT_W - CNT_W){1'b0}}, count_reg};
        end
    endgenerate

    generate
        if (VALUE_BITS >= sle_pkg::FIELD_W)
        begin : g_out_trunc
            assign smallest = head_value[sle_pkg::FIELD_W-1:0];
            assign largest  = tail_value[sle_pkg::FIELD_W-1:0];
        end
        else
        begin : g_out_ext
            assign smallest = {{(sle_pkg::FIELD_W - VALUE_BITS){head_value[VALUE_BITS-1]}},
                               head_value};
            assign largest  = {{(sle_pkg::FIELD_W - VALUE_BITS){tail_value[VALUE_BITS-1]}},
                               tail_value};
        end
    endgenerate

endmodule

`default_nettype wire

@@ hdl/sle_cell.sv @@
`default_nettype none

module sle_cell #(
    parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
) (
    input  wire                          clk,
    input  wire sle_pkg::cell_ctrl_t     ctrl,
    input  wire signed [VALUE_BITS-1:0]  key,
    input  wire        [CNT_W-1:0]       count,
    input  wire signed [VALUE_BITS-1:0]  left_value,
    input  wire                          left_ge,
    input  wire signed [VALUE_BITS-1:0]  right_value,
    output logic signed [VALUE_BITS-1:0] value,
    output logic                         ge,
    output logic                         hit,
    output logic        [VALUE_BITS-1:0] tail_value
);

    logic signed [VALUE_BITS-1:0] value_reg;
    logic signed [VALUE_BITS-1:0] value_next;
    logic                         valid;
    logic                         is_tail;

    assign valid   = count > CNT_W'(IDX);
    assign is_tail = count == CNT_W'(IDX + 1);

    // An empty slot counts as not below the key, so the sorted prefix of
    // smaller entries always ends where the insert or removal point lies.
    assign ge  = !valid || (value_reg >= key);
    assign hit = valid && ge && !left_ge && (value_reg == key);

    assign value      = value_reg;
    assign tail_value = is_tail ? value_reg : '0;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (ge && !left_ge)
            begin
                value_next = key;
            end
            else if (ge)
            begin
                value_next = left_value;
            end
        end
        else if (ctrl.pull_all)
        begin
            value_next = right_value;
        end
        else if (ctrl.pull_ge && ge)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

@@ hdl/sle_checker.sv @@
`default_nettype none

module sle_checker #(
    parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF
) (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 start,
    input wire                                 busy,
    input wire                                 done,
    input wire        [sle_pkg::STATUS_W-1:0]  status,
    input wire        [sle_pkg::COUNT_W-1:0]   entry_count,
    input wire signed [sle_pkg::FIELD_W-1:0]   smallest,
    input wire signed [sle_pkg::FIELD_W-1:0]   largest
);

    // Every accepted transaction yields exactly one result, in the cycle after it is accepted.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("no result after an accepted transaction");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without an accepted transaction");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == sle_pkg::ST_FULL) |->
            entry_count == sle_pkg::COUNT_W'(CAPACITY))
        else $error("full status with the list not at capacity");

    // The count field wraps at 32 entries, so a zero count means empty only
    // for smaller lists.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && entry_count == '0 && CAPACITY < 32) |->
            (smallest == '0 && largest == '0))
        else $error("empty list reports nonzero bounds");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (done && entry_count != '0 && VALUE_BITS <= sle_pkg::FIELD_W) |->
            smallest <= largest)
        else $error("smallest entry above largest entry");

endmodule

bind sorted_list_engine_core sle_checker #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
) u_sle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .entry_count (entry_count),
    .smallest    (smallest),
    .largest     (largest)
);

`default_nettype wire
